// ===== design/aspc_pkg.sv =====
// ----------------------------------------------------------------------------
// aspc_pkg: shared types and constants of the apriori subset prune check
// Item and result structs, action codes, sequencer states and the token
// that travels down the row of candidate cells.
// ----------------------------------------------------------------------------
package aspc_pkg;

	localparam int TABLE_ENTRIES_DEF = 256;
	localparam int MAX_K_DEF         = 8;
	localparam int ITEM_BITS_DEF     = 16;
	localparam int K_BITS            = 4;

	typedef enum logic [1:0] {
		ACT_WRITE_ITEM = 2'd0,
		ACT_WRITE_SIZE = 2'd1,
		ACT_WRITE_CAND = 2'd2,
		ACT_CHECK      = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT
	} state_t;

	typedef struct packed {
		action_t     action;
		logic [7:0]  entry_index;
		logic [3:0]  position;
		logic [15:0] item_value;
		logic [3:0]  entry_size;
		logic [8:0]  entries_in_use;
		logic [3:0]  subset_size;
	} item_t;

	typedef struct packed {
		logic subsets_frequent;
		logic bad_request;
	} result_t;

	// one table entry moving down the cell row
	typedef struct packed {
		logic valid;
		logic last;
		logic ok;
	} chain_tok_t;

endpackage

// ===== design/aspc_table.sv =====
// ----------------------------------------------------------------------------
// aspc_table: frequent itemset table
// One memory bank per element position plus a size memory; a read returns a
// whole entry and starts a token whose ok flag says the stored size equals k.
// ----------------------------------------------------------------------------
module aspc_table #(
	parameter int TABLE_ENTRIES = aspc_pkg::TABLE_ENTRIES_DEF,
	parameter int MAX_K         = aspc_pkg::MAX_K_DEF,
	parameter int ITEM_BITS     = aspc_pkg::ITEM_BITS_DEF,
	localparam int AW           = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_we,
	input  logic                              size_we,
	input  logic [AW-1:0]                     wr_addr,
	input  logic [3:0]                        wr_pos,
	input  logic [ITEM_BITS-1:0]              wr_item,
	input  logic [3:0]                        wr_size,
	input  logic                              rd_en,
	input  logic                              rd_last,
	input  logic [AW-1:0]                     rd_addr,
	input  logic [aspc_pkg::K_BITS-1:0]       k,
	output aspc_pkg::chain_tok_t              tok_out,
	output logic [MAX_K*ITEM_BITS-1:0]        word_out
);

	logic [3:0] size_rd_q;
	logic       rd_valid_q;
	logic       rd_last_q;
	logic [3:0] size_mem [TABLE_ENTRIES];

	for (genvar b = 0; b < MAX_K; b++) begin : g_bank
		logic [ITEM_BITS-1:0] bank_mem [TABLE_ENTRIES];
		always_ff @(posedge clk) begin
			if (item_we && (32'(wr_pos) == b)) begin
				bank_mem[wr_addr] <= wr_item;
			end
			word_out[b*ITEM_BITS +: ITEM_BITS] <= bank_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (size_we) begin
			size_mem[wr_addr] <= wr_size;
		end
		size_rd_q <= size_mem[rd_addr];
		rd_last_q <= rd_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= rd_en;
		end
	end

	always_comb begin
		tok_out.valid = rd_valid_q;
		tok_out.last  = rd_last_q;
		tok_out.ok    = (size_rd_q == k);
	end

endmodule

// ===== design/aspc_cell.sv =====
// ----------------------------------------------------------------------------
// aspc_cell: one candidate element cell
// Holds one candidate element, checks it against the passing table entry and
// hands the entry and the running coverage flag to the next cell.
// ----------------------------------------------------------------------------
module aspc_cell #(
	parameter int CELL_IDX  = 0,
	parameter int MAX_K     = aspc_pkg::MAX_K_DEF,
	parameter int ITEM_BITS = aspc_pkg::ITEM_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [3:0]                        wr_pos,
	input  logic [ITEM_BITS-1:0]              wr_item,
	input  logic [aspc_pkg::K_BITS-1:0]       k,
	input  logic [aspc_pkg::K_BITS-1:0]       skip,
	input  aspc_pkg::chain_tok_t              tok_in,
	input  logic [MAX_K*ITEM_BITS-1:0]        word_in,
	output aspc_pkg::chain_tok_t              tok_out,
	output logic [MAX_K*ITEM_BITS-1:0]        word_out
);

	logic [ITEM_BITS-1:0]   cand_q;
	logic                   tok_valid_q;
	logic                   tok_last_q;
	logic                   tok_ok_q;
	logic [MAX_K*ITEM_BITS-1:0] word_q;
	logic                   hit;
	logic                   cell_free;

	always_comb begin
		hit = 1'b0;
		for (int m = 0; m < MAX_K; m++) begin
			if ((m < int'(k)) && (word_in[m*ITEM_BITS +: ITEM_BITS] == cand_q)) begin
				hit = 1'b1;
			end
		end
		// element left out of this subset, or beyond the candidate
		cell_free = (CELL_IDX > int'(k)) || (CELL_IDX == int'(skip));
	end

	always_ff @(posedge clk) begin
		if (wr_en && (32'(wr_pos) == CELL_IDX)) begin
			cand_q <= wr_item;
		end
		word_q     <= word_in;
		tok_last_q <= tok_in.last;
		tok_ok_q   <= tok_in.ok && (cell_free || hit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in.valid;
		end
	end

	always_comb begin
		tok_out.valid = tok_valid_q;
		tok_out.last  = tok_last_q;
		tok_out.ok    = tok_ok_q;
	end

	assign word_out = word_q;

endmodule

// ===== design/apriori_subset_prune_check_unit.sv =====
// A check reads one table entry per cycle, min(entries_in_use, TABLE_ENTRIES) of them for each
// of its k+1 subsets, and each subset pass ends with the drain of the MAX_K+1 cell row.
// A failing subset ends the check after its pass; a bad request is answered in the cycle after it is accepted.
// Writes are accepted only while the sequencer is idle; one check is worked on at a time.
// Reset clears the sequencer and the result valid flag; table and candidate hold
// whatever they held until written.
// ----------------------------------------------------------------------------
// apriori_subset_prune_check_unit: apriori candidate prune check
// Streams the table through a row of candidate cells once per leave-one-out
// subset and reports whether every subset is a frequent itemset.
// ----------------------------------------------------------------------------
module apriori_subset_prune_check_unit #(
	parameter int TABLE_ENTRIES = aspc_pkg::TABLE_ENTRIES_DEF,
	parameter int MAX_K         = aspc_pkg::MAX_K_DEF,
	parameter int ITEM_BITS     = aspc_pkg::ITEM_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  aspc_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output aspc_pkg::result_t result
);

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int KB = aspc_pkg::K_BITS;

	aspc_pkg::state_t  state_q, state_d;
	logic [AW-1:0]     addr_q, addr_d;
	logic [AW-1:0]     last_addr_q, last_addr_d;
	logic [KB-1:0]     k_q, k_d;
	logic [KB-1:0]     skip_q, skip_d;
	logic              found_q, found_d;
	logic              out_valid_q, out_valid_d;
	aspc_pkg::result_t out_q, out_d;

	logic              accept;
	logic              is_check;
	logic              bad;
	logic              found_now;
	logic              issue_en;
	logic              issue_last;
	logic [31:0]       cnt32;
	logic [31:0]       lim32;
	logic [31:0]       lim_m1;
	logic [31:0]       ent32;
	logic [31:0]       val32;
	logic              ent_ok;

	aspc_pkg::chain_tok_t           tok  [MAX_K+2];
	logic [MAX_K*ITEM_BITS-1:0]     word [MAX_K+2];

	assign is_check   = (item.action == aspc_pkg::ACT_CHECK);
	assign item_stall = (state_q != aspc_pkg::ST_IDLE) || (out_valid_q && is_check);
	assign accept     = item_valid && !item_stall;

	always_comb begin
		cnt32  = 32'(item.entries_in_use);
		lim32  = (cnt32 > 32'(TABLE_ENTRIES)) ? 32'(TABLE_ENTRIES) : cnt32;
		lim_m1 = lim32 - 32'd1;
		bad    = (cnt32 == 32'd0) || (item.subset_size == '0) ||
		         (32'(item.subset_size) > 32'(MAX_K));
		ent32  = 32'(item.entry_index);
		ent_ok = ent32 < 32'(TABLE_ENTRIES);
		val32  = 32'(item.item_value);
	end

	aspc_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.MAX_K        (MAX_K),
		.ITEM_BITS    (ITEM_BITS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_we (accept && (item.action == aspc_pkg::ACT_WRITE_ITEM) && ent_ok),
		.size_we (accept && (item.action == aspc_pkg::ACT_WRITE_SIZE) && ent_ok),
		.wr_addr (ent32[AW-1:0]),
		.wr_pos  (item.position),
		.wr_item (val32[ITEM_BITS-1:0]),
		.wr_size (item.entry_size),
		.rd_en   (issue_en),
		.rd_last (issue_last),
		.rd_addr (addr_q),
		.k       (k_q),
		.tok_out (tok[0]),
		.word_out(word[0])
	);

	for (genvar c = 0; c <= MAX_K; c++) begin : g_cell
		aspc_cell #(
			.CELL_IDX (c),
			.MAX_K    (MAX_K),
			.ITEM_BITS(ITEM_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (accept && (item.action == aspc_pkg::ACT_WRITE_CAND)),
			.wr_pos  (item.position),
			.wr_item (val32[ITEM_BITS-1:0]),
			.k       (k_q),
			.skip    (skip_q),
			.tok_in  (tok[c]),
			.word_in (word[c]),
			.tok_out (tok[c+1]),
			.word_out(word[c+1])
		);
	end

	always_comb begin
		state_d     = state_q;
		addr_d      = addr_q;
		last_addr_d = last_addr_q;
		k_d         = k_q;
		skip_d      = skip_q;
		found_d     = found_q;
		out_valid_d = out_valid_q;
		out_d       = out_q;
		issue_en    = 1'b0;
		issue_last  = (addr_q == last_addr_q);
		found_now   = found_q || tok[MAX_K+1].ok;

		// drop the result once transferred
		if (out_valid_q && !result_stall) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			aspc_pkg::ST_IDLE: begin
				if (accept && is_check) begin
					if (bad) begin
						out_valid_d            = 1'b1;
						out_d.subsets_frequent = 1'b0;
						out_d.bad_request      = 1'b1;
					end else begin
						k_d         = item.subset_size;
						last_addr_d = lim_m1[AW-1:0];
						addr_d      = '0;
						skip_d      = '0;
						found_d     = 1'b0;
						state_d     = aspc_pkg::ST_ISSUE;
					end
				end
			end
			aspc_pkg::ST_ISSUE: begin
				issue_en = 1'b1;
				addr_d   = addr_q + 1'b1;
				// early entries leave the row while later ones are still issued
				if (tok[MAX_K+1].valid) begin
					found_d = found_now;
				end
				if (issue_last) begin
					state_d = aspc_pkg::ST_WAIT;
				end
			end
			aspc_pkg::ST_WAIT: begin
				if (tok[MAX_K+1].valid) begin
					found_d = found_now;
					if (tok[MAX_K+1].last) begin
						if (!found_now || (skip_q == k_q)) begin
							out_valid_d            = 1'b1;
							out_d.subsets_frequent = found_now;
							out_d.bad_request      = 1'b0;
							state_d                = aspc_pkg::ST_IDLE;
						end else begin
							// advance to the next left-out element
							skip_d  = skip_q + 1'b1;
							addr_d  = '0;
							found_d = 1'b0;
							state_d = aspc_pkg::ST_ISSUE;
						end
					end
				end
			end
			default: begin
				state_d = aspc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aspc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		addr_q      <= addr_d;
		last_addr_q <= last_addr_d;
		k_q         <= k_d;
		skip_q      <= skip_d;
		found_q     <= found_d;
		out_q       <= out_d;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
